>>> sv/line_buffer_insert_delete_assert.svh
// assertion macros for the line buffer checker
// no dependencies; included by the checker file only
`ifndef LINE_BUFFER_INSERT_DELETE_ASSERT_SVH
`define LINE_BUFFER_INSERT_DELETE_ASSERT_SVH

// same-cycle implication
`define LBID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line buffer check failed");

// next-cycle implication
`define LBID_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line buffer check failed");

// fixed-latency implication
`define LBID_ASSERT_LAT(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("line buffer check failed");

`endif

>>> sv/lbid_pkg.sv
// shared types and constants for the line buffer
// no dependencies
`timescale 1ns / 1ps

package lbid_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int POS_W        = 9;
  localparam int CHAR_W       = 8;
  localparam int LEN_W        = 9;
  localparam int GRP_SIZE     = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_GATHER = 2'd2
  } state_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

endpackage

>>> sv/lbid_cell.sv
// one byte cell of the line buffer row
// depends on lbid_pkg
`timescale 1ns / 1ps

module lbid_cell #(
  parameter int IDX = 0,
  parameter int AW  = 8
) (
  input  logic                      clk,
  input  lbid_pkg::cell_ctrl_t      ctrl_i,
  input  logic [AW-1:0]             at_i,
  input  logic [lbid_pkg::CHAR_W-1:0] char_i,
  input  logic [lbid_pkg::CHAR_W-1:0] left_i,
  input  logic [lbid_pkg::CHAR_W-1:0] right_i,
  output logic [lbid_pkg::CHAR_W-1:0] data_o,
  output logic [lbid_pkg::CHAR_W-1:0] tap_o
);
  import lbid_pkg::*;

  logic [CHAR_W-1:0] data_r;
  logic [CHAR_W-1:0] data_nxt;
  logic              at_here;
  logic              above_at;

  assign at_here  = (at_i == AW'(IDX));
  assign above_at = (AW'(IDX) > at_i);

  always_comb begin
    data_nxt = data_r;
    if (ctrl_i.ins_en) begin
      if (at_here) begin
        data_nxt = char_i;
      end else if (above_at) begin
        data_nxt = left_i;
      end
    end else if (ctrl_i.del_en) begin
      if (at_here || above_at) begin
        data_nxt = right_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign tap_o  = at_here ? data_r : '0;

endmodule

>>> sv/line_buffer_insert_delete.sv
// line buffer top level: row of byte cells, request sequencer, read gather
// depends on lbid_pkg and lbid_cell
`timescale 1ns / 1ps

// line buffer with insert, delete and read at 1-based positions
//
// request channel: start with in_req_type, in_position, in_char_in; a
//   request is taken on a rising edge with start high and busy low
// result channel: out_valid strobes for exactly one cycle with
//   out_status, out_char_out and out_length; there is no stall
// timing: a request holds busy high through the exec and gather states,
//   and a new request can be taken while its result strobes; the steps
//   are the range check, cell shift and first gather level, then the second
//   level of the read gather into the output register, then the strobe
// the bytes live in a row of CAPACITY cells; an insert moves every cell
//   above the position up by one from its left neighbor, all at once,
//   a delete pulls every cell at or above the position from its right
// reads go through a two-level registered or-tree over the cell taps
// reset clears the fill count, sequencer and strobe; cell contents are
//   left as they are since only cells below the fill count are read
module line_buffer_insert_delete #(
  parameter int CAPACITY = lbid_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [lbid_pkg::POS_W-1:0]  in_position,
  input  logic [lbid_pkg::CHAR_W-1:0] in_char_in,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [lbid_pkg::CHAR_W-1:0] out_char_out,
  output logic [lbid_pkg::LEN_W-1:0]  out_length
);
  import lbid_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int EW   = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int NGRP = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  // sequencer and request hold
  state_t            state_r, state_nxt;
  logic [1:0]        req_r;
  logic [POS_W-1:0]  pos_r;
  logic [CHAR_W-1:0] char_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  status_t           status_r, status_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [LEN_W-1:0]  out_len_r;

  logic              accept;
  logic [EW-1:0]     pos_e, fill_e;
  logic              pos_zero;
  status_t           status_calc;
  cell_ctrl_t        ctrl;
  logic [AW-1:0]     at;

  logic [CHAR_W-1:0] cell_data [CAPACITY];
  logic [CHAR_W-1:0] cell_tap  [CAPACITY];
  logic [CHAR_W-1:0] grp_comb  [NGRP];
  logic [CHAR_W-1:0] grp_r     [NGRP];
  logic [CHAR_W-1:0] gather;

  assign accept   = start && (state_r == S_IDLE);
  assign pos_e    = EW'(pos_r);
  assign fill_e   = EW'(fill_r);
  assign pos_zero = (pos_r == '0);
  // 0-based cell index; a wrap on position zero is harmless, range check blocks it
  assign at       = AW'(pos_r - POS_W'(1));

  // range and capacity check on the held request
  always_comb begin
    status_calc = ST_OK;
    case (req_r)
      REQ_INSERT: begin
        if (pos_zero || (pos_e > fill_e + EW'(1))) begin
          status_calc = ST_RANGE;
        end else if (fill_r == CW'(CAPACITY)) begin
          status_calc = ST_FULL;
        end
      end
      default: begin
        // delete, read, and the unused code which acts as a read
        if (pos_zero || (pos_e > fill_e)) begin
          status_calc = ST_RANGE;
        end
      end
    endcase
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    status_nxt    = status_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    ctrl          = '0;
    busy          = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = status_calc;
        rd_ok_nxt  = (status_calc == ST_OK) && (req_r != REQ_INSERT)
                     && (req_r != REQ_DELETE);
        if (status_calc == ST_OK) begin
          if (req_r == REQ_INSERT) begin
            ctrl.ins_en = 1'b1;
            fill_nxt    = fill_r + CW'(1);
          end else if (req_r == REQ_DELETE) begin
            ctrl.del_en = 1'b1;
            fill_nxt    = fill_r - CW'(1);
          end
        end
        state_nxt = S_GATHER;
      end
      S_GATHER: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rd_ok_r ? gather : '0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      pos_r  <= in_position;
      char_r <= in_char_in;
    end
    status_r   <= status_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_char_r <= out_char_nxt;
    if (state_r == S_GATHER) begin
      out_status_r <= status_r;
      out_len_r    <= LEN_W'(fill_r);
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CHAR_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = char_r;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    lbid_cell #(
      .IDX (i),
      .AW  (AW)
    ) u_cell (
      .clk     (clk),
      .ctrl_i  (ctrl),
      .at_i    (at),
      .char_i  (char_r),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cell_data[i]),
      .tap_o   (cell_tap[i])
    );
  end

  // first gather level: or the taps of each group of cells, registered
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_comb[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          grp_comb[g] = grp_comb[g] | cell_tap[g * GRP_SIZE + j];
        end
      end
    end
    always_ff @(posedge clk) begin
      grp_r[g] <= grp_comb[g];
    end
  end

  // second gather level feeds the output register
  always_comb begin
    gather = '0;
    for (int g = 0; g < NGRP; g++) begin
      gather = gather | grp_r[g];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_char_out = out_char_r;
  assign out_length   = out_len_r;

endmodule

>>> sv/line_buffer_insert_delete_chk.sv
// port-level checker for the line buffer, with its bind
// depends on lbid_pkg and line_buffer_insert_delete_assert.svh
`timescale 1ns / 1ps
`include "line_buffer_insert_delete_assert.svh"

module line_buffer_insert_delete_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [1:0]                  out_status,
  input logic [lbid_pkg::CHAR_W-1:0] out_char_out
);
  import lbid_pkg::*;

  // a taken request holds the block off in the next cycle
  `LBID_ASSERT_NXT(a_busy_after_req, start && !busy, busy)
  // every taken request yields a result strobe
  `LBID_ASSERT_LAT(a_result_latency, start && !busy, 3, out_valid)
  // a result never shows while a request is in flight
  `LBID_ASSERT_IMP(a_idle_on_result, out_valid, !busy)
  // a refused request returns no byte
  `LBID_ASSERT_IMP(a_no_char_on_err, out_valid && (out_status != ST_OK), out_char_out == '0)

endmodule

bind line_buffer_insert_delete line_buffer_insert_delete_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_char_out (out_char_out)
);

>>> sim/line_buffer_insert_delete_test.sv
// self-checking bench for the line buffer: directed edits, then 1000 random requests
// depends on lbid_pkg and the line_buffer_insert_delete rtl
`timescale 1ns / 1ps

module line_buffer_insert_delete_test;
  import lbid_pkg::*;

  localparam int LINE_CAP = DEF_CAPACITY;
  localparam int RANDOM_REQUESTS = 1000;
  // req_type 3 has no enum member; the block treats it as a read
  localparam logic [1:0] REQ_OTHER = 2'd3;
  localparam int PRINT_CAP = 50;

  typedef struct {
    status_t status;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0] length;
  } line_result_t;

  // mirror of the line: predicts one result per accepted request and checks results
  class line_mirror;
    logic [CHAR_W-1:0] cells[LINE_CAP];
    int fill;
    int peak_fill;
    line_result_t pending[$];
    int mismatches;
    int n_insert_ok;
    int n_delete_ok;
    int n_read_ok;
    int n_range;
    int n_full;
    int n_checked;

    function new();
      fill = 0;
      peak_fill = 0;
      mismatches = 0;
      n_insert_ok = 0;
      n_delete_ok = 0;
      n_read_ok = 0;
      n_range = 0;
      n_full = 0;
      n_checked = 0;
    endfunction

    task report(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
        $display("%0t mismatch: %s", $time, what);
      end
    endtask

    function void note_request(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                               input logic [CHAR_W-1:0] ch);
      line_result_t r;
      int at;
      r.status = ST_OK;
      r.char_out = '0;
      if (kind == REQ_INSERT) begin
        if (pos < 1 || pos > fill + 1) begin
          r.status = ST_RANGE;
        end else if (fill >= LINE_CAP) begin
          r.status = ST_FULL;
        end else begin
          at = pos - 1;
          for (int k = fill; k > at; k--) cells[k] = cells[k-1];
          cells[at] = ch;
          fill++;
          n_insert_ok++;
        end
      end else if (kind == REQ_DELETE) begin
        if (pos < 1 || pos > fill) begin
          r.status = ST_RANGE;
        end else begin
          at = pos - 1;
          for (int k = at; k < fill - 1; k++) cells[k] = cells[k+1];
          fill--;
          n_delete_ok++;
        end
      end else begin
        // read and the spare code behave alike
        if (pos < 1 || pos > fill) begin
          r.status = ST_RANGE;
        end else begin
          r.char_out = cells[pos-1];
          n_read_ok++;
        end
      end
      if (r.status == ST_RANGE) n_range++;
      if (r.status == ST_FULL) n_full++;
      if (fill > peak_fill) peak_fill = fill;
      r.length = fill[LEN_W-1:0];
      pending.push_back(r);
    endfunction

    task check_result(input logic [1:0] status, input logic [CHAR_W-1:0] ch,
                      input logic [LEN_W-1:0] length);
      line_result_t e;
      if (pending.size() == 0) begin
        report("result strobe with no request outstanding");
      end else begin
        e = pending.pop_front();
        n_checked++;
        if (status !== e.status)
          report($sformatf("status %0d, expected %0d", status, e.status));
        if (ch !== e.char_out)
          report($sformatf("char_out 0x%02h, expected 0x%02h", ch, e.char_out));
        if (length !== e.length)
          report($sformatf("length %0d, expected %0d", length, e.length));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = REQ_READ;
  logic [POS_W-1:0] in_position = '0;
  logic [CHAR_W-1:0] in_char_in = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [CHAR_W-1:0] out_char_out;
  logic [LEN_W-1:0] out_length;

  line_mirror mirror = new();

  // set during a stretch of the random part where the sender never pauses
  bit steady = 1'b0;
  int accepted = 0;

  line_buffer_insert_delete #(
    .CAPACITY(LINE_CAP)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_position(in_position),
    .in_char_in(in_char_in),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_char_out(out_char_out),
    .out_length(out_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", mirror.pending.size());
    $display("line_buffer_insert_delete_test: errors");
    $finish;
  end

  // results can't be held off, so every strobe is checked at the edge that ends it;
  // reads here see pre-edge values since everything is driven with nonblocking updates
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      mirror.check_result(out_status, out_char_out, out_length);
    end
  end

  // one request: optional idle gap with start low, then hold start until taken.
  // start is only lowered when a gap follows, so back-to-back requests keep it high
  task automatic send_request(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [CHAR_W-1:0] ch);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 33) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_char_in <= ch;
    // taken at the first edge where busy was low while start was high
    do @(posedge clk); while (busy);
    mirror.note_request(kind, pos, ch);
    accepted++;
  endtask

  // position choice: mostly legal, some on the boundaries, the rest mostly out of range
  function automatic logic [POS_W-1:0] pick_position(input logic [1:0] kind, input int fill);
    int limit;
    int r;
    limit = (kind == REQ_INSERT) ? fill + 1 : fill;
    r = $urandom_range(99);
    if (r < 72 && limit >= 1) return POS_W'($urandom_range(1, limit));
    if (r < 82) return (limit >= 1 && $urandom_range(1)) ? POS_W'(limit) : POS_W'(1);
    case ($urandom_range(4))
      0: return '0;
      1: return POS_W'((limit + 1 > 257) ? 257 : limit + 1);
      2: return POS_W'(256);
      3: return POS_W'(257);
      default: return POS_W'($urandom_range(0, 257));
    endcase
  endfunction

  // request mix by phase: balanced, then filling toward full, then draining, then balanced
  function automatic logic [1:0] pick_kind(input int idx);
    int r;
    int ins_w;
    int del_w;
    r = $urandom_range(99);
    if (idx >= 150 && idx < 650) begin
      ins_w = 80;
      del_w = 8;
    end else if (idx >= 650 && idx < 900) begin
      ins_w = 15;
      del_w = 60;
    end else begin
      ins_w = 40;
      del_w = 30;
    end
    if (r < ins_w) return REQ_INSERT;
    if (r < ins_w + del_w) return REQ_DELETE;
    if (r < 97) return REQ_READ;
    return REQ_OTHER;
  endfunction

  initial begin
    logic [1:0] kind;
    logic [POS_W-1:0] pos;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty line: every read and delete is out of range, inserts at zero and past the end too
    send_request(REQ_READ, 9'd1, 8'h00);
    send_request(REQ_DELETE, 9'd1, 8'h00);
    send_request(REQ_INSERT, 9'd0, 8'h11);
    send_request(REQ_INSERT, 9'd2, 8'h22);
    // build a short line with extreme bytes in the middle and at the back
    send_request(REQ_INSERT, 9'd1, 8'h00);
    send_request(REQ_INSERT, 9'd2, 8'hFF);
    send_request(REQ_INSERT, 9'd1, 8'hA5);
    send_request(REQ_INSERT, 9'd2, 8'h5A);
    send_request(REQ_READ, 9'd1, 8'hFF);
    send_request(REQ_READ, 9'd2, 8'h00);
    send_request(REQ_READ, 9'd3, 8'h00);
    send_request(REQ_READ, 9'd4, 8'h00);
    // position zero and past the end for reads and deletes, past the end for insert
    send_request(REQ_READ, 9'd5, 8'h00);
    send_request(REQ_READ, 9'd0, 8'h00);
    send_request(REQ_DELETE, 9'd0, 8'h00);
    send_request(REQ_DELETE, 9'd5, 8'h00);
    send_request(REQ_INSERT, 9'd257, 8'h33);
    send_request(REQ_READ, 9'd256, 8'h00);
    // spare request code reads
    send_request(REQ_OTHER, 9'd1, 8'hFF);
    send_request(REQ_OTHER, 9'd0, 8'h00);
    // delete from middle, end and front
    send_request(REQ_DELETE, 9'd2, 8'h00);
    send_request(REQ_DELETE, 9'd3, 8'h00);
    send_request(REQ_DELETE, 9'd1, 8'hFF);
    send_request(REQ_READ, 9'd1, 8'h00);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i >= 400 && i < 560);
      kind = pick_kind(i);
      pos = pick_position(kind, mirror.fill);
      send_request(kind, pos, 8'($urandom_range(255)));
    end
    start <= 1'b0;

    // drain: wait for outstanding results, then wait for stray strobes
    for (int c = 0; c < 200 && mirror.pending.size() != 0; c++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.pending.size() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.pending.size()));

    $display("%0d requests, %0d results checked, peak length %0d of %0d",
             accepted, mirror.n_checked, mirror.peak_fill, LINE_CAP);
    $display("inserts %0d, deletes %0d, reads %0d, out of range %0d, refused full %0d",
             mirror.n_insert_ok, mirror.n_delete_ok, mirror.n_read_ok, mirror.n_range,
             mirror.n_full);
    if (mirror.mismatches == 0) begin
      $display("line_buffer_insert_delete_test: clean");
    end else begin
      $display("line_buffer_insert_delete_test: errors");
    end
    $finish;
  end

endmodule
